### hw/rtl/hns_pkg.sv
package hns_pkg;

   // Default capacity of the row buffers, in samples.
   localparam int MAX_WIDTH_DEF = 1024;

   // Largest supported row count.
   localparam int ROWS_MAX = 4096;

   // Reset values of the configuration registers.
   localparam logic [10:0] GRID_WIDTH_RST = 11'd256;
   localparam logic [12:0] GRID_ROWS_RST  = 13'd256;

   // Configuration register indexes.
   localparam logic CSR_GRID_WIDTH = 1'b0;
   localparam logic CSR_GRID_ROWS  = 1'b1;

   // One pending normal: the two central differences and its grid position.
   typedef struct packed {
      logic signed [16:0] dx;
      logic signed [16:0] dz;
      logic [9:0]         col;
      logic [11:0]        row;
      logic               last;
   } entry_type;

endpackage

### hw/rtl/heightmap_normal_stream.sv
// A sample releases up to three normals; the front end queues them, and the back
// end normalizes one at a time, with the three-stage multiply-compare pipeline
// that searches 15 bits for each of three components, then holds the result word.
// The front end takes a new sample only once the last one's normals are queued.
// Reset: synchronous, active high; registers return to 256 by 256, position 0.
module heightmap_normal_stream import hns_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [12:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // height
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // normal_x, normal_y, normal_z, column, row
   output logic        rsp_tlast
);

   logic      push_valid, push_ready, pop_valid, pop_ready;
   entry_type push_entry, pop_entry;

   // Sample intake, row buffers and difference setup.
   hns_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // Queue of pending normals.
   hns_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Normalization unit and result register.
   hns_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### hw/rtl/hns_front.sv
module hns_front import hns_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [12:0]       csr_wdata,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,
   output logic              push_valid,
   input  logic              push_ready,
   output entry_type         push_entry
);

   localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_RD1  = 2'd1;
   localparam logic [1:0] F_RD2  = 2'd2;
   localparam logic [1:0] F_PUSH = 2'd3;

   logic [1:0]         state_ff;
   logic [10:0]        gw_ff;
   logic [12:0]        gr_ff;
   logic [CW-1:0]      col_ff;
   logic [11:0]        row_ff;
   logic signed [15:0] p1_ff, p2_ff, pa_ff, h_ff, a_ff, b_ff;
   logic signed [15:0] rd_a_ff, rd_b_ff;
   logic signed [15:0] mem_a [MAX_WIDTH];
   logic signed [15:0] mem_b [MAX_WIDTH];
   entry_type          em_ff [3];
   logic [2:0]         em_v_ff;
   logic [WW-1:0]      w;
   logic [12:0]        rows;
   logic [CW-1:0]      rd_addr;
   entry_type          e_in [3];
   logic [2:0]         e_v_in;
   logic               wrap, last_row;
   logic signed [15:0] l0, r0, d0, l1;

   // Clamp the registers to their legal ranges.
   always_comb begin
      if (gw_ff < 11'd2) w = WW'(2);
      else if (32'(gw_ff) > MAX_WIDTH) w = WW'(MAX_WIDTH);
      else w = WW'(gw_ff);
      if (gr_ff < 13'd2) rows = 13'd2;
      else if (32'(gr_ff) > ROWS_MAX) rows = 13'(ROWS_MAX);
      else rows = gr_ff;
   end

   assign req_tready = (state_ff == F_IDLE);
   assign rd_addr    = (state_ff == F_RD1) ? CW'(32'(col_ff) + 32'd1) : col_ff;
   assign wrap       = (32'(col_ff) + 32'd1) >= 32'(w);
   assign last_row   = (13'(row_ff) + 13'd1) == rows;

   // Row buffers: one read and one write port each.
   always_ff @(posedge clock) begin
      if (state_ff == F_RD2) begin
         mem_a[col_ff] <= h_ff;
         mem_b[col_ff] <= a_ff;
      end
      rd_a_ff <= mem_a[rd_addr];
      rd_b_ff <= mem_b[col_ff];
   end

   // Build the up to three normals that this sample releases.
   always_comb begin
      l0 = (col_ff != '0) ? pa_ff : a_ff;
      r0 = ((32'(col_ff) + 32'd1) < 32'(w)) ? rd_a_ff : a_ff;
      d0 = (row_ff > 12'd1) ? b_ff : a_ff;
      l1 = (32'(col_ff) >= 32'd2) ? p2_ff : p1_ff;

      e_in[0].dx   = {r0[15], r0} - {l0[15], l0};
      e_in[0].dz   = {h_ff[15], h_ff} - {d0[15], d0};
      e_in[0].col  = 10'(col_ff);
      e_in[0].row  = row_ff - 12'd1;
      e_in[0].last = 1'b0;

      e_in[1].dx   = {h_ff[15], h_ff} - {l1[15], l1};
      e_in[1].dz   = {p1_ff[15], p1_ff} - {pa_ff[15], pa_ff};
      e_in[1].col  = 10'(32'(col_ff) - 32'd1);
      e_in[1].row  = row_ff;
      e_in[1].last = 1'b0;

      e_in[2].dx   = {h_ff[15], h_ff} - {p1_ff[15], p1_ff};
      e_in[2].dz   = {h_ff[15], h_ff} - {a_ff[15], a_ff};
      e_in[2].col  = 10'(col_ff);
      e_in[2].row  = row_ff;
      e_in[2].last = 1'b1;

      e_v_in[0] = (row_ff != 12'd0);
      e_v_in[1] = last_row && (col_ff != '0);
      e_v_in[2] = last_row && wrap;
   end

   // Hand the pending normals to the queue, oldest first.
   always_comb begin
      push_valid = (state_ff == F_PUSH) && (em_v_ff != 3'd0);
      if (em_v_ff[0]) push_entry = em_ff[0];
      else if (em_v_ff[1]) push_entry = em_ff[1];
      else push_entry = em_ff[2];
   end

   // Data path registers.
   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE) h_ff <= req_tdata;
      if (state_ff == F_RD1) begin
         a_ff <= rd_a_ff;
         b_ff <= rd_b_ff;
      end
      if (state_ff == F_RD2) begin
         em_ff <= e_in;
         pa_ff <= a_ff;
      end
   end

   // Control: sequencer, position counters and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         gw_ff    <= GRID_WIDTH_RST;
         gr_ff    <= GRID_ROWS_RST;
         col_ff   <= '0;
         row_ff   <= '0;
         p1_ff    <= '0;
         p2_ff    <= '0;
         em_v_ff  <= '0;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (req_tvalid) state_ff <= F_RD1;
            end
            F_RD1: begin
               state_ff <= F_RD2;
            end
            F_RD2: begin
               em_v_ff  <= e_v_in;
               state_ff <= F_PUSH;
               if (wrap) begin
                  col_ff <= '0;
                  p1_ff  <= '0;
                  p2_ff  <= '0;
                  row_ff <= last_row ? 12'd0 : row_ff + 12'd1;
               end else begin
                  col_ff <= col_ff + CW'(1);
                  p1_ff  <= h_ff;
                  p2_ff  <= p1_ff;
               end
            end
            F_PUSH: begin
               if (em_v_ff == 3'd0) state_ff <= F_IDLE;
               else if (push_ready) begin
                  if (em_v_ff[0]) em_v_ff[0] <= 1'b0;
                  else if (em_v_ff[1]) em_v_ff[1] <= 1'b0;
                  else em_v_ff[2] <= 1'b0;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
         if (csr_we) begin
            if (csr_index == CSR_GRID_WIDTH) gw_ff <= csr_wdata[10:0];
            else gr_ff <= csr_wdata;
            col_ff <= '0;
            row_ff <= '0;
            p1_ff  <= '0;
            p2_ff  <= '0;
         end
      end
   end

endmodule

### hw/rtl/hns_queue.sv
module hns_queue import hns_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_entry
);

   entry_type  slot_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff;
   logic       do_push, do_pop;

   assign push_ready = (cnt_ff != 3'd4);
   assign pop_valid  = (cnt_ff != 3'd0);
   assign pop_entry  = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Storage for the queued words.
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_entry;
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 2'd1;
         if (do_pop) rd_ff <= rd_ff + 2'd1;
         if (do_push && !do_pop) cnt_ff <= cnt_ff + 3'd1;
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - 3'd1;
      end
   end

endmodule

### hw/rtl/hns_back.sv
module hns_back import hns_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  entry_type   pop_entry,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam logic [2:0] B_IDLE  = 3'd0;
   localparam logic [2:0] B_SQ    = 3'd1;
   localparam logic [2:0] B_SUM   = 3'd2;
   localparam logic [2:0] B_ITER  = 3'd3;
   localparam logic [2:0] B_DRAIN = 3'd4;
   localparam logic [2:0] B_DONE  = 3'd5;

   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;

   localparam logic [14:0] ONE_Q14 = 15'd16384;

   logic [2:0]  state_ff;
   entry_type   ent_ff;
   logic [31:0] ax2_ff, az2_ff;
   logic [33:0] s_ff;
   logic [61:0] tx_ff, tz_ff;
   logic [14:0] q_ff [3];
   logic [1:0]  comp_ff;
   logic [3:0]  bit_ff;
   logic        s1_v_ff, s2_v_ff;
   logic [1:0]  s1_comp_ff, s2_comp_ff;
   logic [14:0] s1_cand_ff, s2_cand_ff;
   logic        s1_ok_ff, s2_ok_ff;
   logic [31:0] s1_sq_ff;
   logic [48:0] plo_ff, phi_ff;
   logic        rsp_tvalid_ff, rsp_tlast_ff;
   logic [71:0] rsp_tdata_ff;
   logic [15:0] ax, az;
   logic [14:0] cand;
   logic [15:0] odd;
   logic [65:0] prod;
   logic [61:0] target;
   logic        keep, load_out;
   logic [15:0] nx, nz;

   assign pop_ready  = (state_ff == B_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign load_out   = (state_ff == B_DONE) && (!rsp_tvalid_ff || rsp_tready);

   // Magnitudes of the differences.
   assign ax = ent_ff.dx[16] ? 16'(-ent_ff.dx) : ent_ff.dx[15:0];
   assign az = ent_ff.dz[16] ? 16'(-ent_ff.dz) : ent_ff.dz[15:0];

   // Candidate of the current bit for the component in issue.
   assign cand = q_ff[comp_ff] | (15'd1 << bit_ff);
   assign odd  = {cand, 1'b0} - 16'd1;

   // Final stage: sum of the partial products against the target.
   always_comb begin
      prod = 66'(plo_ff) + (66'(phi_ff) << 17);
      case (s2_comp_ff)
         COMP_X:  target = tx_ff;
         COMP_Y:  target = 62'd1 << 48;
         COMP_Z:  target = tz_ff;
         default: target = tx_ff;
      endcase
      keep = s2_v_ff && s2_ok_ff && (prod <= 66'(target));
   end

   // Signs go on after rounding; a component is minus its difference.
   assign nx = (!ent_ff.dx[16] && ent_ff.dx != '0) ? 16'(-{1'b0, q_ff[COMP_X]})
                                                   : {1'b0, q_ff[COMP_X]};
   assign nz = (!ent_ff.dz[16] && ent_ff.dz != '0) ? 16'(-{1'b0, q_ff[COMP_Z]})
                                                   : {1'b0, q_ff[COMP_Z]};

   // Data path: squares, sum, three-stage search pipeline, result word.
   always_ff @(posedge clock) begin
      if (state_ff == B_IDLE) ent_ff <= pop_entry;
      if (state_ff == B_SQ) begin
         ax2_ff <= ax * ax;
         az2_ff <= az * az;
      end
      if (state_ff == B_SUM) begin
         s_ff  <= 34'(ax2_ff) + 34'(az2_ff) + (34'd1 << 18);
         tx_ff <= 62'(ax2_ff) << 30;
         tz_ff <= 62'(az2_ff) << 30;
         q_ff[COMP_X] <= '0;
         q_ff[COMP_Y] <= '0;
         q_ff[COMP_Z] <= '0;
      end else if (keep) begin
         q_ff[s2_comp_ff] <= s2_cand_ff;
      end
      s1_comp_ff <= comp_ff;
      s1_cand_ff <= cand;
      s1_ok_ff   <= (cand <= ONE_Q14);
      s1_sq_ff   <= odd * odd;
      s2_comp_ff <= s1_comp_ff;
      s2_cand_ff <= s1_cand_ff;
      s2_ok_ff   <= s1_ok_ff;
      plo_ff     <= s1_sq_ff * s_ff[16:0];
      phi_ff     <= s1_sq_ff * s_ff[33:17];
      if (load_out) begin
         rsp_tdata_ff <= {3'd0, ent_ff.row, ent_ff.col, nz, q_ff[COMP_Y], nx};
         rsp_tlast_ff <= ent_ff.last;
      end
   end

   // Control: sequencer, issue counters and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         comp_ff       <= COMP_X;
         bit_ff        <= 4'd14;
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         s1_v_ff <= (state_ff == B_ITER);
         s2_v_ff <= s1_v_ff;
         case (state_ff)
            B_IDLE: begin
               if (pop_valid) state_ff <= B_SQ;
            end
            B_SQ: begin
               state_ff <= B_SUM;
            end
            B_SUM: begin
               comp_ff  <= COMP_X;
               bit_ff   <= 4'd14;
               state_ff <= B_ITER;
            end
            B_ITER: begin
               if (comp_ff == COMP_Z) begin
                  comp_ff <= COMP_X;
                  if (bit_ff == 4'd0) state_ff <= B_DRAIN;
                  else bit_ff <= bit_ff - 4'd1;
               end else begin
                  comp_ff <= comp_ff + 2'd1;
               end
            end
            B_DRAIN: begin
               if (!s1_v_ff && !s2_v_ff) state_ff <= B_DONE;
            end
            B_DONE: begin
               if (load_out) state_ff <= B_IDLE;
            end
            default: state_ff <= B_IDLE;
         endcase
         if (load_out) rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
      end
   end

endmodule

### test/heightmap_normal_checker.sv
module heightmap_normal_checker import hns_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [12:0] csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          normals_waiting,
   output int          normals_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0] nx;
      logic [14:0] ny;
      logic [15:0] nz;
      logic [9:0]  col;
      logic [11:0] row;
      logic        last;
   } normal_t;

   // Predictor state: configuration, the two buffered rows and the position.
   logic [10:0] width_reg;
   logic [12:0] rows_reg;
   int          line_above [MAX_WIDTH_DEF];
   int          line_two_above [MAX_WIDTH_DEF];
   int          prev_one;
   int          prev_two;
   int          col_pos;
   int          row_pos;
   normal_t     expected_normals [$];

   // Largest q with q/16384 <= |v|/sqrt(s) rounded to nearest, ties away from zero.
   function automatic int unsigned unit_component(int unsigned mag, longint unsigned s);
      longint unsigned goal;
      longint unsigned odd;
      int unsigned     q;
      int unsigned     cand;
      goal = (longint'(mag) * mag) << 30;
      q = 0;
      for (int b = 14; b >= 0; b--) begin
         cand = q | (1 << b);
         odd  = 2 * longint'(cand) - 1;
         if (cand <= 16384 && odd * odd * s <= goal) q = cand;
      end
      return q;
   endfunction

   function automatic logic [15:0] negated_component(int diff, int unsigned q);
      logic [15:0] v;
      v = q[15:0];
      return (diff > 0) ? -v : v;
   endfunction

   function automatic void predict_normal(int lft, int rgt, int dn, int up,
                                          int c, int r, bit fin);
      normal_t          n;
      int               dx;
      int               dz;
      int unsigned      ax;
      int unsigned      az;
      longint unsigned  s;
      dx = rgt - lft;
      dz = up - dn;
      ax = (dx < 0) ? -dx : dx;
      az = (dz < 0) ? -dz : dz;
      s  = longint'(ax) * ax + longint'(az) * az + 512 * 512;
      n.nx   = negated_component(dx, unit_component(ax, s));
      n.ny   = 15'(unit_component(512, s));
      n.nz   = negated_component(dz, unit_component(az, s));
      n.col  = 10'(c);
      n.row  = 12'(r);
      n.last = fin;
      expected_normals.insert(expected_normals.size(), n);
   endfunction

   function automatic void predict_sample(logic [15:0] raw);
      int w;
      int rr;
      int c;
      int r;
      int h;
      int a;
      int b;
      w  = (width_reg < 2) ? 2 : (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
      rr = (rows_reg < 2) ? 2 : (rows_reg > ROWS_MAX) ? ROWS_MAX : rows_reg;
      c  = (col_pos >= w) ? 0 : col_pos;
      r  = (row_pos >= rr) ? 0 : row_pos;
      h  = $signed(raw);
      a  = line_above[c];
      b  = line_two_above[c];
      // Normal of the point one row up, released by this sample.
      if (r >= 1)
         predict_normal((c > 0) ? line_two_above[c - 1] : a,
                        (c + 1 < w) ? line_above[c + 1] : a,
                        (r >= 2) ? b : a, h, c, r - 1, 1'b0);
      // The final row also flushes its own normals.
      if (r + 1 == rr) begin
         if (c >= 1)
            predict_normal((c >= 2) ? prev_two : prev_one, h,
                           line_two_above[c - 1], prev_one, c - 1, r, 1'b0);
         if (c + 1 == w)
            predict_normal(prev_one, h, a, h, c, r, 1'b1);
      end
      line_two_above[c] = a;
      line_above[c] = h;
      prev_two = prev_one;
      prev_one = h;
      c++;
      if (c >= w) begin
         c = 0;
         prev_one = 0;
         prev_two = 0;
         r++;
         if (r >= rr) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endfunction

   // Track configuration and accepted words, then compare each result word.
   always @(posedge clock) begin
      normal_t got;
      normal_t exp_n;
      if (reset) begin
         width_reg = GRID_WIDTH_RST;
         rows_reg  = GRID_ROWS_RST;
         prev_one  = 0;
         prev_two  = 0;
         col_pos   = 0;
         row_pos   = 0;
         fail_count = 0;
         normals_checked = 0;
         expected_normals.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_GRID_WIDTH) width_reg = csr_wdata[10:0];
            else rows_reg = csr_wdata;
            col_pos  = 0;
            row_pos  = 0;
            prev_one = 0;
            prev_two = 0;
         end
         if (req_tvalid && req_tready) predict_sample(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[15:0], rsp_tdata[30:16], rsp_tdata[46:31],
                   rsp_tdata[56:47], rsp_tdata[68:57], rsp_tlast};
            normals_checked++;
            if (expected_normals.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result word, expected nothing, actual %p",
                        $time, got);
            end else begin
               exp_n = expected_normals.pop_front();
               if (got !== exp_n || rsp_tdata[71:69] !== 3'b000) begin
                  fail_count++;
                  $display("%0t: normal mismatch, expected %p, actual %p (pad %b)",
                           $time, exp_n, got, rsp_tdata[71:69]);
               end
            end
         end
      end
      normals_waiting = expected_normals.size();
   end

endmodule

### test/heightmap_normal_stream_tb.sv
module heightmap_normal_stream_tb import hns_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_GRID_WIDTH;
   logic [12:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   int          fail_count;
   int          normals_waiting;
   int          normals_checked;
   bit          idling_on = 1'b1;
   bit          hold_request = 1'b0;
   bit          hold_taken = 1'b0;
   int          hold_off = 0;
   int          words_sent = 0;
   int          grids_run = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   heightmap_normal_stream u_top (.*);

   heightmap_normal_checker u_check (.*);

   // Result side: random back-pressure, plus one long hold-off when requested.
   always @(posedge clock) begin
      if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_off <= 700;
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(idling_on && $urandom_range(99) < 8);
      end
   end

   task automatic write_reg(logic idx, logic [12:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait for all normals, then let the front end finish a silent sample.
   task automatic drain();
      @(posedge clock);
      while (normals_waiting != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic send_word(logic [15:0] h);
      if (idling_on && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= h;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic configure(logic [12:0] w, logic [12:0] r);
      drain();
      write_reg(CSR_GRID_WIDTH, w);
      write_reg(CSR_GRID_ROWS, r);
      grids_run++;
   endtask

   // Mostly smooth terrain so the normals vary, sometimes full-range samples.
   function automatic logic [15:0] terrain(ref int level);
      if ($urandom_range(3) == 0) level = $signed(16'($urandom));
      else level = level + $urandom_range(0, 1200) - 600;
      if (level > 32767) level = 32767;
      if (level < -32768) level = -32768;
      return level[15:0];
   endfunction

   task automatic send_rows(int w, int nrows);
      int level;
      level = 0;
      for (int i = 0; i < w * nrows; i++) send_word(terrain(level));
      req_tvalid <= 1'b0;
   endtask

   initial begin
      int w;
      int r;
      logic [15:0] corner [4];
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Default 256 by 256 grid: part of row zero gives no normals.
      for (int i = 0; i < 8; i++) send_word(16'($urandom));
      req_tvalid <= 1'b0;

      // Width and rows below range clamp to a 2 by 2 grid: height extremes.
      configure(13'd0, 13'd1);
      corner = '{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF};
      foreach (corner[i]) send_word(corner[i]);
      corner = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0000};
      foreach (corner[i]) send_word(corner[i]);
      req_tvalid <= 1'b0;

      // Flat 3 by 3 grid, then a sloped one.
      configure(13'd3, 13'd3);
      for (int i = 0; i < 9; i++) send_word(16'h0100);
      for (int i = 0; i < 9; i++) send_word(16'(i * 700 - 3000));
      req_tvalid <= 1'b0;

      // Long receiver hold-off while the sender keeps offering words.
      configure(13'd5, 13'd4);
      hold_request = 1'b1;
      send_rows(5, 4);

      // Out-of-range width and rows clamp to the limits.
      configure(13'd2047, 13'd2);
      send_rows(16, 1);
      configure(13'd2, 13'd8191);
      send_rows(2, 6);

      // Random small grids; every fifth grid setting runs without any idling.
      while (words_sent < 270) begin
         idling_on = (grids_run % 5 != 3);
         w = $urandom_range(2, 9);
         r = $urandom_range(2, 6);
         configure(13'(w), 13'(r));
         send_rows(w, (($urandom_range(4) == 0) ? $urandom_range(1, r) : r));
      end
      idling_on = 1'b1;

      drain();
      $display("Covered %0d grid settings, %0d height words and %0d checked normals.",
               grids_run, words_sent, normals_checked);
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #40ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
